/* src/mbp_pkg.sv */
package mbp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = 6;
    localparam int IDX_BITS  = 10;

    localparam logic [CNT_BITS-1:0] FIELD_CAP = 6'd32;
    localparam logic [CNT_BITS-1:0] WORD_LEN  = 6'd32;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic                  is_flush;
        logic [WORD_BITS-1:0]  field;
        logic [CNT_BITS-1:0]   n;
    } mbp_cmd_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]  word;
        logic [IDX_BITS-1:0]   index;
        logic                  flushed;
    } mbp_res_t;

    typedef struct packed {
        logic [CNT_BITS-1:0]   pending;
        logic                  emit;
    } mbp_status_t;

endpackage

/* src/mbp_front.sv */
module mbp_front
    import mbp_pkg::*;
(
    input  logic                 push,
    input  logic                 full,
    input  logic                 mode,
    input  logic [31:0]          value,
    input  logic [5:0]           bit_count,
    input  logic                 signed_field,
    output logic                 enq,
    output mbp_cmd_t             cmd
);

    logic [CNT_BITS-1:0]  n;
    logic [WORD_BITS-1:0] mask_all;
    logic [WORD_BITS-1:0] mask_mag;
    logic [WORD_BITS-1:0] mag;
    logic [WORD_BITS-1:0] sign_bit;
    logic                 neg;

    always_comb
    begin
        n        = (bit_count > FIELD_CAP) ? FIELD_CAP : bit_count;
        mask_all = ~({WORD_BITS{1'b1}} << n);
        mask_mag = ~({WORD_BITS{1'b1}} << (n - 6'd1));
        neg      = value[31];
        mag      = neg ? (~value + 32'd1) : value;
        sign_bit = {{(WORD_BITS-1){1'b0}}, neg} << (n - 6'd1);

        cmd.is_flush = (mode == MODE_FLUSH);
        cmd.n        = n;
        if (signed_field)
        begin
            cmd.field = sign_bit | (mag & mask_mag);
        end
        else
        begin
            cmd.field = value & mask_all;
        end

        enq = push && !full && ((mode == MODE_FLUSH) || (bit_count != 6'd0));
    end

endmodule

/* src/mbp_cmd_queue.sv */
module mbp_cmd_queue
    import mbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      enq,
    input  mbp_cmd_t  enq_cmd,
    output logic      full,
    input  logic      deq,
    output logic      head_valid,
    output mbp_cmd_t  head_cmd
);

    mbp_cmd_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        head_valid  = (count_reg != 2'd0);
        head_cmd    = entry_reg[rd_ptr_reg];
        wr_ptr_next = enq ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= enq_cmd;
        end
    end

endmodule

/* src/mbp_back.sv */
module mbp_back
    import mbp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    input  mbp_cmd_t     cmd,
    output logic         cmd_take,
    input  logic         pop,
    output logic         empty,
    output mbp_res_t     res,
    output mbp_status_t  status
);

    logic [WORD_BITS-1:0] scratch_reg, scratch_next;
    logic [CNT_BITS-1:0]  pending_reg, pending_next;
    logic [IDX_BITS-1:0]  next_word_reg, next_word_next;

    mbp_res_t   buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    logic                   deq;
    logic                   emit;
    logic [2*WORD_BITS-1:0] cat;
    logic [CNT_BITS:0]      total;
    logic [CNT_BITS-1:0]    rest;
    logic [2*WORD_BITS-1:0] shifted;
    logic [2*WORD_BITS-1:0] rest_mask;
    logic [WORD_BITS-1:0]   flush_word;
    mbp_res_t               new_res;

    always_comb
    begin
        empty    = (count_reg == 2'd0);
        res      = buf_reg[rd_ptr_reg];
        deq      = pop && !empty;
        cmd_take = cmd_valid && ((count_reg != 2'd2) || deq);

        cat        = ({{WORD_BITS{1'b0}}, scratch_reg} << cmd.n)
                     | {{WORD_BITS{1'b0}}, cmd.field};
        total      = {1'b0, pending_reg} + {1'b0, cmd.n};
        rest       = total[CNT_BITS-1:0] - WORD_LEN;
        shifted    = cat >> rest;
        rest_mask  = ~({(2*WORD_BITS){1'b1}} << rest);
        flush_word = scratch_reg << (WORD_LEN - pending_reg);

        scratch_next   = scratch_reg;
        pending_next   = pending_reg;
        emit           = 1'b0;
        new_res.index   = next_word_reg;
        new_res.flushed = cmd.is_flush;
        new_res.word    = cmd.is_flush ? flush_word : shifted[WORD_BITS-1:0];

        if (cmd_take)
        begin
            if (cmd.is_flush)
            begin
                if (pending_reg != 6'd0)
                begin
                    emit         = 1'b1;
                    scratch_next = '0;
                    pending_next = '0;
                end
            end
            else if (total >= {1'b0, WORD_LEN})
            begin
                emit         = 1'b1;
                scratch_next = cat[WORD_BITS-1:0] & rest_mask[WORD_BITS-1:0];
                pending_next = rest;
            end
            else
            begin
                scratch_next = cat[WORD_BITS-1:0];
                pending_next = total[CNT_BITS-1:0];
            end
        end

        next_word_next = emit ? next_word_reg + 10'd1 : next_word_reg;
        wr_ptr_next    = emit ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = deq ? ~rd_ptr_reg : rd_ptr_reg;
        count_next     = count_reg + {1'b0, emit} - {1'b0, deq};

        status.pending = pending_reg;
        status.emit    = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scratch_reg   <= '0;
            pending_reg   <= '0;
            next_word_reg <= '0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
        end
        else
        begin
            scratch_reg   <= scratch_next;
            pending_reg   <= pending_next;
            next_word_reg <= next_word_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            buf_reg[wr_ptr_reg] <= new_res;
        end
    end

endmodule

/* src/msb_first_bit_packer.sv */
// MSB-first bit packer.
// Input queue: an item is taken at a rising edge with push high and full low.
// A write item (mode 0) appends bit_count bits of value, sign plus magnitude
// when signed_field is set; widths above 32 are treated as 32 and a width of
// zero does nothing. A flush item (mode 1) emits the pending partial word, if
// there is one, zero-padded at the low end, with flushed set.
// Result queue: while empty is low, word, word_pos and flushed show the
// oldest result; it is taken at a rising edge with pop high.
// An accepted item is registered in the two-entry command queue; the packing
// stage takes it from there and writes any result word into the result buffer,
// and empty goes low once the result buffer holds a word.
// Throughput is one item per cycle while the result buffer has room or is
// being popped; the shift and merge of the packing stage are combinational.
// When pop stays low the two-entry result buffer fills, the packing stage
// stops, the command queue fills and full rises; no item is lost.
// Reset clears the pending bits, the word index and both queues.
module msb_first_bit_packer
    import mbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [31:0] value,
    input  logic [5:0]  bit_count,
    input  logic        signed_field,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] word,
    output logic [9:0]  word_pos,
    output logic        flushed
);

    logic        enq;
    mbp_cmd_t    enq_cmd;
    logic        head_valid;
    mbp_cmd_t    head_cmd;
    logic        cmd_take;
    mbp_res_t    res;
    mbp_status_t status;

    mbp_front u_front (
        .push         (push),
        .full         (full),
        .mode         (mode),
        .value        (value),
        .bit_count    (bit_count),
        .signed_field (signed_field),
        .enq          (enq),
        .cmd          (enq_cmd)
    );

    mbp_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq        (enq),
        .enq_cmd    (enq_cmd),
        .full       (full),
        .deq        (cmd_take),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    mbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .res       (res),
        .status    (status)
    );

    assign word     = res.word;
    assign word_pos = res.index;
    assign flushed  = res.flushed;

    logic                have_prev_reg;
    logic [IDX_BITS-1:0] prev_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_idx_reg  <= '0;
        end
        else if (pop && !empty)
        begin
            have_prev_reg <= 1'b1;
            prev_idx_reg  <= word_pos;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && have_prev_reg) |-> (word_pos == prev_idx_reg + 10'd1))
        else $error("Result word index does not follow the previous one.");

    assert property (@(posedge clk) disable iff (!rst_n)
        status.pending < WORD_LEN)
        else $error("Pending bit count reached a full word.");

    assert property (@(posedge clk) disable iff (!rst_n)
        status.emit |-> cmd_take)
        else $error("Result emitted without a command being taken.");

endmodule

/* tb/msb_first_bit_packer_tb.sv */
`timescale 1ns / 1ps

module msb_first_bit_packer_tb
    import mbp_pkg::*;
();

    typedef struct {
        logic        mode;
        logic [31:0] value;
        logic [5:0]  bit_count;
        logic        signed_field;
    } packer_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        mode = MODE_WRITE;
    logic [31:0] value = '0;
    logic [5:0]  bit_count = '0;
    logic        signed_field = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] word;
    logic [9:0]  word_pos;
    logic        flushed;

    packer_item_t items_to_send[$];
    mbp_res_t     expected_words[$];

    logic [63:0] acc_bits = '0;
    int          acc_count = 0;
    logic [9:0]  acc_index = '0;

    int errors = 0;
    int items_sent = 0;
    int words_checked = 0;
    int flush_words = 0;
    int signed_fields = 0;
    int full_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stretch_left = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int holds_done = 0;

    msb_first_bit_packer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .value        (value),
        .bit_count    (bit_count),
        .signed_field (signed_field),
        .empty        (empty),
        .pop          (pop),
        .word         (word),
        .word_pos     (word_pos),
        .flushed      (flushed)
    );

    always #6 clk = ~clk;

    task automatic emit_word(input logic [31:0] w, input logic last);
        mbp_res_t r;
        r.word    = w;
        r.index   = acc_index;
        r.flushed = last;
        expected_words.push_back(r);
        acc_index = acc_index + 10'd1;
    endtask

    task automatic pack_field(input packer_item_t it);
        logic [63:0] field;
        logic [31:0] mag;
        logic [63:0] shifted;
        int n;
        int rest;
        if (it.mode == MODE_FLUSH)
        begin
            if (acc_count != 0)
            begin
                shifted = acc_bits << (WORD_BITS - acc_count);
                emit_word(shifted[31:0], 1'b1);
                acc_bits  = '0;
                acc_count = 0;
            end
            return;
        end
        n = int'(it.bit_count);
        if (n == 0)
            return;
        if (n > WORD_BITS)
            n = WORD_BITS;
        if (it.signed_field)
        begin
            mag   = it.value[31] ? (32'd0 - it.value) : it.value;
            field = ({63'd0, it.value[31]} << (n - 1))
                  | ({32'd0, mag} & ((64'd1 << (n - 1)) - 64'd1));
        end
        else
        begin
            field = {32'd0, it.value} & ((64'd1 << n) - 64'd1);
        end
        acc_bits  = (acc_bits << n) | field;
        acc_count = acc_count + n;
        if (acc_count >= WORD_BITS)
        begin
            rest    = acc_count - WORD_BITS;
            shifted = acc_bits >> rest;
            emit_word(shifted[31:0], 1'b0);
            acc_bits  = acc_bits & ((64'd1 << rest) - 64'd1);
            acc_count = rest;
        end
    endtask

    task automatic add_item(input logic m, input logic [31:0] v, input logic [5:0] n,
                            input logic s);
        packer_item_t it;
        it.mode         = m;
        it.value        = v;
        it.bit_count    = n;
        it.signed_field = s;
        items_to_send.push_back(it);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255);
            1: return 32'd0 - $urandom_range(1, 255);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 6'd0;
        else if (r < 35)
            return 6'($urandom_range(1, 23));
        else if (r < 85)
            return 6'($urandom_range(24, 32));
        else
            return 6'($urandom_range(33, 63));
    endfunction

    always @(posedge clk)
    begin : driver
        logic taken;
        taken = push && !full;
        if (rst_n)
        begin
            if (taken)
            begin
                pack_field(items_to_send.pop_front());
                items_sent <= items_sent + 1;
                if (signed_field && mode == MODE_WRITE)
                    signed_fields <= signed_fields + 1;
            end
            if (!push || taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    push <= 1'b0;
                end
                else if (items_to_send.size() != 0)
                begin
                    mode         <= items_to_send[0].mode;
                    value        <= items_to_send[0].value;
                    bit_count    <= items_to_send[0].bit_count;
                    signed_field <= items_to_send[0].signed_field;
                    push         <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left = burst_left - 1;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if ((holds_done == 0 && items_sent >= 300)
                     || (holds_done == 1 && items_sent >= 1000))
            begin
                hold_left  <= 250;
                holds_done <= holds_done + 1;
            end
            if (push && full)
                full_cycles <= full_cycles + 1;
        end
    end

    always @(posedge clk)
    begin : monitor
        mbp_res_t exp_w;
        int       bad;
        bad = 0;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word %h index %0d flushed %0b",
                             $time, word, word_pos, flushed);
                    bad = bad + 1;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    words_checked <= words_checked + 1;
                    if (exp_w.flushed)
                        flush_words <= flush_words + 1;
                    if (word !== exp_w.word)
                    begin
                        $display("%0t: word expected %h actual %h", $time, exp_w.word, word);
                        bad = bad + 1;
                    end
                    if (word_pos !== exp_w.index)
                    begin
                        $display("%0t: word_pos expected %0d actual %0d",
                                 $time, exp_w.index, word_pos);
                        bad = bad + 1;
                    end
                    if (flushed !== exp_w.flushed)
                    begin
                        $display("%0t: flushed expected %0b actual %0b",
                                 $time, exp_w.flushed, flushed);
                        bad = bad + 1;
                    end
                end
                if (bad != 0)
                    errors <= errors + bad;
            end
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 70;
                endcase
            end
            else
            begin
                stretch_left = stretch_left - 1;
            end
            pop <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        packer_item_t it;
        int r;

        add_item(MODE_WRITE, 32'h0000_0001, 6'd1,  1'b0);
        add_item(MODE_WRITE, 32'hffff_ffff, 6'd32, 1'b0);
        add_item(MODE_WRITE, 32'h0000_0000, 6'd31, 1'b0);
        add_item(MODE_FLUSH, 32'h1234_5678, 6'd7,  1'b1);
        add_item(MODE_WRITE, 32'hffff_ffff, 6'd0,  1'b0);
        add_item(MODE_WRITE, 32'ha5a5_5a5a, 6'd63, 1'b0);
        add_item(MODE_WRITE, 32'h0f0f_f0f0, 6'd33, 1'b1);
        add_item(MODE_WRITE, 32'h8000_0000, 6'd32, 1'b1);
        add_item(MODE_WRITE, 32'hffff_ffff, 6'd1,  1'b1);
        add_item(MODE_WRITE, 32'h0000_0005, 6'd1,  1'b1);
        add_item(MODE_WRITE, 32'hffff_fff9, 6'd4,  1'b1);
        add_item(MODE_WRITE, 32'h0000_0064, 6'd8,  1'b1);
        add_item(MODE_WRITE, 32'hdead_beef, 6'd12, 1'b0);
        add_item(MODE_FLUSH, 32'h0000_0000, 6'd0,  1'b0);
        add_item(MODE_FLUSH, 32'hffff_ffff, 6'd63, 1'b0);
        add_item(MODE_WRITE, 32'h7fff_ffff, 6'd32, 1'b1);
        add_item(MODE_WRITE, 32'h8000_0000, 6'd5,  1'b1);
        add_item(MODE_WRITE, 32'hffff_ffff, 6'd20, 1'b0);
        add_item(MODE_FLUSH, 32'hcafe_f00d, 6'd40, 1'b1);

        for (int i = 0; i < 1630; i++)
        begin
            r = $urandom_range(0, 99);
            it.mode         = (r < 6) ? MODE_FLUSH : MODE_WRITE;
            it.value        = pick_value();
            it.bit_count    = pick_count();
            it.signed_field = 1'($urandom_range(0, 1));
            items_to_send.push_back(it);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (items_to_send.size() != 0 || expected_words.size() != 0 || push);
        repeat (10) @(posedge clk);

        $display("Sent %0d items (%0d signed fields), checked %0d words, %0d of them flushed.",
                 items_sent, signed_fields, words_checked, flush_words);
        $display("Input was held off by a full queue for %0d cycles over %0d long stalls.",
                 full_cycles, holds_done);
        if (errors == 0)
            $display("** msb_first_bit_packer: PASSED **");
        else
            $display("** msb_first_bit_packer: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d items unsent and %0d words outstanding.",
                 items_to_send.size(), expected_words.size());
        $display("** msb_first_bit_packer: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
src/mbp_pkg.sv
src/mbp_front.sv
src/mbp_cmd_queue.sv
src/mbp_back.sv
src/msb_first_bit_packer.sv
tb/msb_first_bit_packer_tb.sv
